>>> rtl/acrms_pkg.sv
// Shared constants, register codes and types for the AC cycle true-RMS block.
package acrms_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int MAX_WINDOW = 256;
  localparam int WIN_W      = $clog2(MAX_WINDOW + 2);
  localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
  localparam int GAIN_W     = 24;
  localparam int OFFSET_W   = 18;
  localparam int CYCLES_W   = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam int SUM_W      = 48;
  localparam int RMS_W      = 20;
  localparam int MAG_W      = 20;
  localparam int PROD_W     = SAMPLE_W + GAIN_W + 1;
  localparam int SQ_W       = 2 * MAG_W;
  localparam int FRAC_SHIFT = 12;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W     = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);

  localparam logic [GAIN_W-1:0]          GAIN_RESET   = GAIN_W'(20972);
  localparam logic signed [OFFSET_W-1:0] OFFSET_RESET = '0;
  localparam logic [CYCLES_W-1:0]        CYCLES_RESET = CYCLES_W'(2);
  localparam logic [CYCLES_W-1:0]        CROSS_MAX    = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN   = 2'd0,
    REG_OFFSET = 2'd1,
    REG_CYCLES = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [GAIN_W-1:0]          gain;
    logic signed [OFFSET_W-1:0] offset;
    logic [CYCLES_W-1:0]        cycles;
  } cfg_t;

  // Per-window summary handed from the front end to the back end.
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] count;
    logic             ok;
  } summary_t;

endpackage

>>> rtl/acrms_in_if.sv
// Sample input channel: valid/ready with one raw sample and the window-end mark.
interface acrms_in_if;
  import acrms_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       last_sample;

  modport source (output valid, output sample, output last_sample, input ready);
  modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

>>> rtl/acrms_out_if.sv
// Result output channel: valid/ready with rms, success and sample count.
interface acrms_out_if;
  import acrms_pkg::*;

  logic             valid;
  logic             ready;
  logic [RMS_W-1:0] rms;
  logic             success;
  logic [CNT_W-1:0] samples_used;

  modport source (output valid, output rms, output success, output samples_used,
                  input ready);
  modport sink   (input valid, input rms, input success, input samples_used,
                  output ready);
endinterface

>>> rtl/acrms_cfg_if.sv
// Configuration write channel: valid/ready with register index and data.
interface acrms_cfg_if;
  import acrms_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/acrms_front.sv
// Front end: crossing detection, window bookkeeping and scale/square/accumulate pipe.
module acrms_front
  import acrms_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  acrms_in_if.sink    samples,
  output logic        push_valid,
  input  logic        push_ready,
  output summary_t    push_data
);

  typedef struct packed {
    logic             acc;
    logic             last;
    logic             ok;
    logic [CNT_W-1:0] count;
  } ctrl_t;

  localparam logic signed [MAG_W+9:0] Q_LIMIT = (MAG_W+10)'((1 << MAG_W) - 1);

  // window state
  logic                       have_previous;
  logic signed [SAMPLE_W-1:0] previous_sample;
  logic [CYCLES_W-1:0]        crossings_seen;
  logic [CNT_W-1:0]           accumulated_count;
  logic [WIN_W-1:0]           window_length;
  logic [SUM_W-1:0]           square_sum;

  // pipeline stages
  logic                       a_valid, b_valid, c_valid, d_valid;
  ctrl_t                      a_ctrl, b_ctrl, c_ctrl, d_ctrl;
  logic signed [SAMPLE_W-1:0] a_sample;
  logic signed [PROD_W-1:0]   b_prod;
  logic [MAG_W-1:0]           c_mag;
  logic [SQ_W-1:0]            d_sq;

  logic                       advance;
  logic                       accept;
  logic [WIN_W-1:0]           window_length_next;
  logic                       in_window;
  logic                       crossing;
  logic [CYCLES_W-1:0]        crossings_next;
  logic                       acc_now;
  logic [CNT_W-1:0]           count_next;
  logic                       ok_now;
  logic signed [GAIN_W:0]     gain_s;
  logic signed [PROD_W-1:0]   rounded;
  logic signed [MAG_W+9:0]    q_off;
  logic signed [MAG_W+9:0]    q_sat;
  logic [MAG_W+9:0]           q_abs;
  logic [SUM_W:0]             sum_add;
  logic [SUM_W-1:0]           sum_next;

  assign push_valid     = d_valid && d_ctrl.last;
  assign advance        = !(push_valid && !push_ready);
  assign samples.ready  = advance;
  assign accept         = samples.valid && advance;

  always_comb begin
    window_length_next = (window_length <= WIN_W'(MAX_WINDOW)) ?
                         window_length + WIN_W'(1) : window_length;
    in_window      = window_length_next <= WIN_W'(MAX_WINDOW);
    crossing       = in_window && have_previous && (previous_sample <= 0) &&
                     (samples.sample > 0) && (crossings_seen != CROSS_MAX);
    crossings_next = crossing ? crossings_seen + CYCLES_W'(1) : crossings_seen;
    acc_now        = in_window && (crossings_next != '0) && (crossings_next <= cfg.cycles);
    count_next     = acc_now ? accumulated_count + CNT_W'(1) : accumulated_count;
    ok_now         = in_window && (cfg.cycles != '0) &&
                     ({1'b0, crossings_next} >= ({1'b0, cfg.cycles} + (CYCLES_W+1)'(1))) &&
                     (count_next != '0);
  end

  // Round Q.24 to Q.12 with halves up, add offset, clamp, take magnitude.
  always_comb begin
    gain_s  = $signed({1'b0, cfg.gain});
    rounded = (b_prod + PROD_W'(2048)) >>> FRAC_SHIFT;
    q_off   = (MAG_W+10)'(rounded) + (MAG_W+10)'(cfg.offset);
    if (q_off > Q_LIMIT) begin
      q_sat = Q_LIMIT;
    end else if (q_off < -Q_LIMIT) begin
      q_sat = -Q_LIMIT;
    end else begin
      q_sat = q_off;
    end
    q_abs = (q_sat < 0) ? $unsigned(-q_sat) : $unsigned(q_sat);
  end

  always_comb begin
    sum_add  = {1'b0, square_sum} + (SUM_W+1)'(d_sq);
    sum_next = square_sum;
    if (d_ctrl.acc) begin
      sum_next = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
    end
  end

  assign push_data.sum   = sum_next;
  assign push_data.count = d_ctrl.count;
  assign push_data.ok    = d_ctrl.ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      have_previous     <= 1'b0;
      previous_sample   <= '0;
      crossings_seen    <= '0;
      accumulated_count <= '0;
      window_length     <= '0;
      square_sum        <= '0;
      a_valid           <= 1'b0;
      b_valid           <= 1'b0;
      c_valid           <= 1'b0;
      d_valid           <= 1'b0;
    end else if (advance) begin
      a_valid <= accept;
      b_valid <= a_valid;
      c_valid <= b_valid;
      d_valid <= c_valid;
      if (accept) begin
        if (samples.last_sample) begin
          have_previous     <= 1'b0;
          previous_sample   <= '0;
          crossings_seen    <= '0;
          accumulated_count <= '0;
          window_length     <= '0;
        end else begin
          window_length     <= window_length_next;
          crossings_seen    <= crossings_next;
          accumulated_count <= count_next;
          if (in_window) begin
            previous_sample <= samples.sample;
            have_previous   <= 1'b1;
          end
        end
      end
      if (d_valid) begin
        square_sum <= d_ctrl.last ? '0 : sum_next;
      end
    end
  end

  // payload stages, no reset
  always_ff @(posedge clk) begin
    if (advance) begin
      a_sample    <= samples.sample;
      a_ctrl.acc  <= acc_now;
      a_ctrl.last <= samples.last_sample;
      a_ctrl.ok   <= ok_now;
      a_ctrl.count <= count_next;
      b_prod      <= a_sample * gain_s;
      b_ctrl      <= a_ctrl;
      c_mag       <= q_abs[MAG_W-1:0];
      c_ctrl      <= b_ctrl;
      d_sq        <= c_mag * c_mag;
      d_ctrl      <= c_ctrl;
    end
  end

endmodule

>>> rtl/acrms_queue.sv
// Short summary queue between the front end and the back end.
module acrms_queue
  import acrms_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push_valid,
  output logic     push_ready,
  input  summary_t push_data,
  output logic     pop_valid,
  input  logic     pop_ready,
  output summary_t pop_data
);

  summary_t          entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;
  logic              do_push;
  logic              do_pop;

  assign push_ready = fill != QCNT_W'(QUEUE_DEPTH);
  assign pop_valid  = fill != '0;
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

>>> rtl/acrms_back.sv
// Back end: bit-serial mean divide, two-bit-a-step integer root, result register.
module acrms_back
  import acrms_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      pop_valid,
  output logic      pop_ready,
  input  summary_t  pop_data,
  acrms_out_if.source results
);

  typedef enum logic [1:0] {
    IDLE,
    DIV,
    ROOT,
    HOLD
  } state_t;

  localparam int STEP_W = $clog2(SUM_W);
  localparam logic [SUM_W-1:0] ROOT_BIT0 = SUM_W'(1) << (SUM_W - 2);

  state_t            state;
  logic [STEP_W-1:0] step;
  logic [SUM_W-1:0]  num;
  logic [CNT_W-1:0]  den;
  logic [CNT_W-1:0]  rem;
  logic [SUM_W-1:0]  root;
  logic [SUM_W-1:0]  rbit;

  logic [CNT_W:0]    rem_sh;
  logic              div_ge;
  logic [CNT_W:0]    rem_sub;
  logic [SUM_W:0]    trial;
  logic              root_ge;

  assign pop_ready = state == IDLE;

  always_comb begin
    rem_sh  = {rem, num[SUM_W-1]};
    div_ge  = rem_sh >= {1'b0, den};
    rem_sub = rem_sh - {1'b0, den};
    trial   = {1'b0, root} + {1'b0, rbit};
    root_ge = {1'b0, num} >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= IDLE;
      results.valid <= 1'b0;
    end else begin
      case (state)
        IDLE: begin
          if (pop_valid) begin
            den                  <= pop_data.count;
            results.success      <= pop_data.ok;
            if (pop_data.ok) begin
              results.samples_used <= pop_data.count;
              num   <= pop_data.sum;
              rem   <= '0;
              step  <= STEP_W'(SUM_W - 1);
              state <= DIV;
            end else begin
              results.rms          <= '0;
              results.samples_used <= '0;
              results.valid        <= 1'b1;
              state                <= HOLD;
            end
          end
        end
        DIV: begin
          num <= {num[SUM_W-2:0], div_ge};
          rem <= div_ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
          if (step == '0) begin
            root  <= '0;
            rbit  <= ROOT_BIT0;
            step  <= STEP_W'(SUM_W / 2 - 1);
            state <= ROOT;
          end else begin
            step <= step - STEP_W'(1);
          end
        end
        ROOT: begin
          if (root_ge) begin
            num  <= num - trial[SUM_W-1:0];
            root <= (root >> 1) + rbit;
          end else begin
            root <= root >> 1;
          end
          rbit <= rbit >> 2;
          if (step == '0) begin
            state <= HOLD;
          end else begin
            step <= step - STEP_W'(1);
          end
        end
        HOLD: begin
          if (!results.valid) begin
            results.valid <= 1'b1;
            results.rms   <= (root > SUM_W'((1 << RMS_W) - 1)) ? '1 : root[RMS_W-1:0];
          end else if (results.ready) begin
            results.valid <= 1'b0;
            state         <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/ac_cycle_true_rms_core.sv
// Top level of the AC cycle true-RMS block: config registers, front end, queue, back end.
//
// Streams signed converter samples, one beat per sample, and returns one result
// beat per capture window on the beat marked last_sample. Accumulation runs
// from the first positive-going zero crossing up to, not including, the
// crossing that completes `cycles` further full cycles; each sample is scaled
// by gain (Q.24 per LSB) and offset (Q.12), squared and summed. The result is
// floor(sqrt(sum / count)) in Q.12 with a success flag; a window with too few
// crossings, cycles set to zero, or more than 256 samples gives rms 0, success
// 0 and samples_used 0. Samples are accepted one per clock while the summary
// queue has room: the front end is a four-stage scale/square/accumulate pipe.
// Per window, the back end runs the bit-serial mean divide and then the integer
// root before it presents the result; a failed window skips both. A two-entry
// summary queue lets the front end keep taking samples while the back end
// works; windows shorter than one back-end pass, sent back to back, will
// stall the input once the queue fills. Configuration writes are taken every
// cycle and must only occur while idle.
module ac_cycle_true_rms_core
  import acrms_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  acrms_cfg_if.sink     cfg,
  acrms_in_if.sink      samples,
  acrms_out_if.source   results
);

  cfg_t     cfg_regs;
  logic     push_valid;
  logic     push_ready;
  summary_t push_data;
  logic     pop_valid;
  logic     pop_ready;
  summary_t pop_data;

  // Register writes never stall; indexes past the last register are dropped.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.gain   <= GAIN_RESET;
      cfg_regs.offset <= OFFSET_RESET;
      cfg_regs.cycles <= CYCLES_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_GAIN:   cfg_regs.gain   <= cfg.data[GAIN_W-1:0];
        REG_OFFSET: cfg_regs.offset <= $signed(cfg.data[OFFSET_W-1:0]);
        REG_CYCLES: cfg_regs.cycles <= cfg.data[CYCLES_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Front end: crossing tracking and the per-sample accumulate pipe.
  acrms_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg_regs),
    .samples    (samples),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // Hold finished window summaries until the back end is free.
  acrms_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // Back end: mean and root, then present the result beat.
  acrms_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .results   (results)
  );

endmodule

>>> test/ac_cycle_true_rms_core_tb.sv
// Self-checking testbench for the AC cycle true-RMS core: driven windows checked against a predictor.
module ac_cycle_true_rms_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import acrms_pkg::*;

  localparam int     RESET_CYCLES = 10;
  // Pause after the last result so the back end is idle before touching registers.
  localparam int     DRAIN_PAUSE  = 100;
  // Long receiver hold-off: long enough for the two-entry summary queue to fill.
  localparam int     LONG_HOLD    = 600;
  // Slowest legal quiet stretch is the long hold plus a back-end pass; allow many times that.
  localparam int     IDLE_LIMIT   = 5000;
  // Sample budget for the whole run, and the share kept back for the closing stretch.
  localparam int     ITEM_TARGET  = 1250;
  localparam int     STEADY_ITEMS = 200;
  localparam longint Q12_MAX      = 1048575;
  localparam longint unsigned SUM_MAX = 64'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic [RMS_W-1:0] rms;
    logic             success;
    logic [CNT_W-1:0] used;
  } rms_result_t;

  // Shapes of capture window the stimulus can build.
  typedef enum int {
    WIN_CYCLES,  // enough full periods for the configured cycle count
    WIN_SHORT,   // too few crossings
    WIN_NOISE,   // uncorrelated full-range samples
    WIN_LONG     // more than MAX_WINDOW samples
  } window_kind_t;

  logic clk;
  logic rst;

  acrms_cfg_if cfg_bus ();
  acrms_in_if  smp_bus ();
  acrms_out_if res_bus ();

  ac_cycle_true_rms_core i_dut (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_bus),
    .samples (smp_bus),
    .results (res_bus)
  );

  // Predictor copy of the configuration registers.
  logic [GAIN_W-1:0]          gain_q   = GAIN_RESET;
  logic signed [OFFSET_W-1:0] offset_q = OFFSET_RESET;
  logic [CYCLES_W-1:0]        cycles_q = CYCLES_RESET;

  // Predictor copy of the per-window state.
  bit                         have_prev = 1'b0;
  logic signed [SAMPLE_W-1:0] prev_s    = '0;
  int                         crossings = 0;
  longint unsigned            sq_sum    = 0;
  int                         acc_count = 0;
  int                         win_len   = 0;

  // Results predicted for closed windows, oldest first.
  rms_result_t pending_rms[$];

  int errors          = 0;
  int results_checked = 0;
  int windows_ok      = 0;
  int windows_sent    = 0;
  int samples_sent    = 0;
  int cfg_writes      = 0;
  int idle_cycles     = 0;

  bit gaps_on       = 1'b1;
  bit stalls_on     = 1'b1;
  bit long_hold_req = 1'b0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Raw sample to Q.12: round the Q.24 product half-up, add offset, saturate.
  function automatic longint scale_q12(input logic signed [SAMPLE_W-1:0] s);
    longint prod;
    prod = longint'(s) * longint'(gain_q) + 2048;
    prod = (prod >>> FRAC_SHIFT) + longint'(offset_q);
    if (prod > Q12_MAX) prod = Q12_MAX;
    else if (prod < -Q12_MAX) prod = -Q12_MAX;
    return prod;
  endfunction

  // Floor square root, built one result bit at a time (inputs stay below 2^49).
  function automatic longint unsigned floor_sqrt(input longint unsigned x);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 25; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= x) root = trial;
    end
    return root;
  endfunction

  // Advance the window state by one accepted sample beat; close the window on the mark.
  function automatic void window_step(input logic signed [SAMPLE_W-1:0] s, input logic last);
    longint          mag;
    longint unsigned root;
    rms_result_t     res;
    bit              ok;
    if (win_len <= MAX_WINDOW) win_len++;
    if (win_len <= MAX_WINDOW) begin
      // Positive-going crossing needs a predecessor from this same window.
      if (have_prev && prev_s <= 0 && s > 0 && crossings < int'(CROSS_MAX)) crossings++;
      if (crossings >= 1 && crossings <= int'(cycles_q)) begin
        mag = scale_q12(s);
        if (mag < 0) mag = -mag;
        sq_sum += longint'(mag * mag);
        if (sq_sum > SUM_MAX) sq_sum = SUM_MAX;
        acc_count++;
      end
      prev_s    = s;
      have_prev = 1'b1;
    end
    if (!last) return;
    ok = win_len <= MAX_WINDOW && cycles_q != 0 && crossings >= int'(cycles_q) + 1 &&
         acc_count > 0;
    res.rms     = '0;
    res.success = ok;
    res.used    = '0;
    if (ok) begin
      root = floor_sqrt(sq_sum / longint'(acc_count));
      if (root > Q12_MAX) root = Q12_MAX;
      res.rms  = root[RMS_W-1:0];
      res.used = acc_count[CNT_W-1:0];
    end
    pending_rms.push_back(res);
    have_prev = 1'b0;
    prev_s    = '0;
    crossings = 0;
    sq_sum    = 0;
    acc_count = 0;
    win_len   = 0;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what);
    errors++;
    $display("MISMATCH at %0t: %s", $time, what);
  endtask

  task automatic check_result();
    rms_result_t want;
    if (pending_rms.size() == 0) begin
      report_mismatch($sformatf("result beat with nothing pending: rms %0d success %0d used %0d",
                                res_bus.rms, res_bus.success, res_bus.samples_used));
      return;
    end
    want = pending_rms.pop_front();
    results_checked++;
    if (want.success) windows_ok++;
    if (res_bus.rms !== want.rms)
      report_mismatch($sformatf("rms got %0d want %0d", res_bus.rms, want.rms));
    if (res_bus.success !== want.success)
      report_mismatch($sformatf("success got %0d want %0d", res_bus.success, want.success));
    if (res_bus.samples_used !== want.used)
      report_mismatch($sformatf("samples_used got %0d want %0d", res_bus.samples_used,
                                want.used));
  endtask

  // Watch all three channels at each edge: registers, samples, then results.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_bus.valid && cfg_bus.ready) begin
        case (cfg_reg_t'(cfg_bus.index))
          REG_GAIN:   gain_q   = cfg_bus.data[GAIN_W-1:0];
          REG_OFFSET: offset_q = cfg_bus.data[OFFSET_W-1:0];
          REG_CYCLES: cycles_q = cfg_bus.data[CYCLES_W-1:0];
          default: ;
        endcase
      end
      if (smp_bus.valid && smp_bus.ready) window_step(smp_bus.sample, smp_bus.last_sample);
      if (res_bus.valid && res_bus.ready) check_result();
    end
  end

  // Watchdog: end the run if no beat moves on any channel for too long.
  always @(posedge clk) begin
    if (rst || (cfg_bus.valid && cfg_bus.ready) || (smp_bus.valid && smp_bus.ready) ||
        (res_bus.valid && res_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("TIMEOUT: no beat accepted for %0d cycles, %0d results outstanding",
               idle_cycles, pending_rms.size());
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result receiver: random stall bursts, plus a long hold-off on request.
  initial begin
    int hold_left;
    int burst_left;
    hold_left  = 0;
    burst_left = 0;
    res_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left     = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_bus.ready <= 1'b0;
      end else if (burst_left > 0) begin
        burst_left--;
        res_bus.ready <= 1'b0;
      end else if (stalls_on && $urandom_range(0, 6) == 0) begin
        burst_left = $urandom_range(1, 5) - 1;
        res_bus.ready <= 1'b0;
      end else begin
        res_bus.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Offer one sample beat and hold it until taken; valid stays up for the next beat.
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic last);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      smp_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    smp_bus.valid       <= 1'b1;
    smp_bus.sample      <= s;
    smp_bus.last_sample <= last;
    do @(posedge clk); while (!smp_bus.ready);
    samples_sent++;
  endtask

  task automatic idle_input();
    smp_bus.valid <= 1'b0;
  endtask

  // Hold until every predicted result has come back, then let the back end settle.
  task automatic wait_drained();
    while (pending_rms.size() != 0) @(posedge clk);
    repeat (DRAIN_PAUSE) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_writes++;
  endtask

  // Write all three registers back to back; only call with the block drained.
  task automatic apply_config(input logic [GAIN_W-1:0] g, input logic signed [OFFSET_W-1:0] o,
                              input logic [CYCLES_W-1:0] c);
    write_reg(REG_GAIN, CFG_DATA_W'(g));
    write_reg(REG_OFFSET, CFG_DATA_W'(o));
    write_reg(REG_CYCLES, CFG_DATA_W'(c));
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic apply_random_config();
    logic [GAIN_W-1:0]          g;
    logic signed [OFFSET_W-1:0] o;
    logic [CYCLES_W-1:0]        c;
    case ($urandom_range(0, 7))
      0:       g = '1;
      1:       g = '0;
      2, 3:    g = GAIN_W'($urandom_range(0, 24'hFF_FFFF));
      default: g = GAIN_W'($urandom_range(1, 4 * 20972));
    endcase
    case ($urandom_range(0, 7))
      0:       o = {1'b0, {(OFFSET_W-1){1'b1}}};
      1:       o = {1'b1, {(OFFSET_W-1){1'b0}}};
      2:       o = OFFSET_W'($urandom());
      default: o = OFFSET_W'($urandom_range(0, 8000) - 4000);
    endcase
    case ($urandom_range(0, 19))
      0:       c = '0;
      1:       c = '1;
      default: c = CYCLES_W'($urandom_range(1, 8));
    endcase
    apply_config(g, o, c);
  endtask

  // Build one capture window: a triangle wave with optional DC and noise, or plain noise.
  task automatic send_window(input window_kind_t kind, input int force_len = 0,
                             input bit full_scale = 1'b0);
    int     cyc;
    int     pmax;
    int     period;
    int     half;
    int     phase;
    int     len;
    int     amp;
    int     dc;
    int     noise;
    int     pos;
    longint ramp;
    longint v;
    logic [31:0] raw;
    cyc    = (cycles_q == 0) ? 1 : ((cycles_q > 8) ? 8 : int'(cycles_q));
    pmax   = MAX_WINDOW / (cyc + 2);
    // Favor short periods so most windows stay short and close often.
    period = ($urandom_range(0, 3) != 0) ? $urandom_range(4, (pmax < 12) ? pmax : 12)
                                         : $urandom_range(4, pmax);
    half   = period / 2;
    phase  = $urandom_range(0, period - 1);
    amp    = full_scale ? 32767 : $urandom_range(1, (1 << $urandom_range(1, 15)) - 1);
    dc     = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, amp / 2)) - amp / 4 : 0;
    noise  = ($urandom_range(0, 3) == 0) ? amp / 8 : 0;
    case (kind)
      WIN_CYCLES: len = period * (cyc + 2) - $urandom_range(0, half);
      WIN_SHORT:  len = $urandom_range(1, period * cyc);
      WIN_NOISE:  len = $urandom_range(1, 40);
      default:    len = $urandom_range(MAX_WINDOW + 1, MAX_WINDOW + 44);
    endcase
    if (force_len > 0) len = force_len;
    for (int k = 0; k < len; k++) begin
      if (kind == WIN_NOISE) begin
        raw = $urandom();
        v   = longint'($signed(raw[SAMPLE_W-1:0]));
      end else begin
        pos = (k + phase) % period;
        if (pos < half) ramp = -amp + (2 * longint'(amp) * pos) / half;
        else ramp = amp - (2 * longint'(amp) * (pos - half)) / (period - half);
        v = ramp + dc;
        if (noise > 0) v += int'($urandom_range(0, 2 * noise)) - noise;
        if (v > 32767) v = 32767;
        else if (v < -32768) v = -32768;
      end
      send_sample(v[SAMPLE_W-1:0], k == len - 1);
    end
    windows_sent++;
  endtask

  function automatic window_kind_t pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return WIN_CYCLES;
    if (r < 82) return WIN_SHORT;
    if (r < 97) return WIN_NOISE;
    return WIN_LONG;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset settings (cycles set to 2): full-range samples, crossings from zero and from
  // negative, a single-sample window, too few crossings, and a window that opens
  // positive right after one that closed at zero, which must not count as a crossing.
  task automatic test_directed_crossings();
    logic signed [SAMPLE_W-1:0] pts [21] = '{32767, -32768, 5, -3, 0, 7, 0, 1,
                                             1,
                                             -5, 3, -2, 4, 0,
                                             9, -1, 2, -1, 2, -1, 2};
    bit ends [21] = '{0, 0, 0, 0, 0, 0, 0, 1,
                      1,
                      0, 0, 0, 0, 1,
                      0, 0, 0, 0, 0, 0, 1};
    for (int k = 0; k < 21; k++) send_sample(pts[k], ends[k]);
    windows_sent += 4;
    idle_input();
    wait_drained();
  endtask

  // Register extremes: max/zero gain, both offset rails, a cycles setting of 1 and of 8, and
  // the two settings that can never succeed (a cycles setting of 0 or of 15).
  task automatic test_config_extremes();
    logic [GAIN_W-1:0]          g_set [5] = '{'1, '0, '1, 20972, '1};
    logic signed [OFFSET_W-1:0] o_set [5] = '{131071, -131072, -131072, 131071, 0};
    logic [CYCLES_W-1:0]        c_set [5] = '{8, 1, 15, 0, 3};
    for (int k = 0; k < 5; k++) begin
      apply_config(g_set[k], o_set[k], c_set[k]);
      // Full-scale wave at maximum gain drives the scaled samples into saturation.
      send_window(WIN_CYCLES, 0, g_set[k] == '1);
      send_window(WIN_NOISE);
      idle_input();
      wait_drained();
    end
  endtask

  // Window length around the limit: exactly MAX_WINDOW passes, one more fails.
  task automatic test_window_limit();
    apply_config(20972, 0, 2);
    send_window(WIN_CYCLES, MAX_WINDOW);
    send_window(WIN_CYCLES, MAX_WINDOW + 1);
    send_window(WIN_CYCLES);
    idle_input();
    wait_drained();
  endtask

  // Hold the result side off while short windows keep coming, so the summary queue
  // fills and the input stalls; then pause the sender until everything is back.
  task automatic test_backpressure();
    apply_config(20972, 0, 1);
    gaps_on       = 1'b0;
    long_hold_req = 1'b1;
    repeat (12) send_window(WIN_CYCLES, 8);
    idle_input();
    wait_drained();
    gaps_on = 1'b1;
    send_window(WIN_CYCLES);
    idle_input();
    wait_drained();
  endtask

  // Random phases: new settings, idling on or off per side, a few windows; run at
  // least one phase and stop once the sample budget, less the closing stretch, is spent.
  task automatic test_random_windows();
    do begin
      apply_random_config();
      gaps_on   = $urandom_range(0, 3) != 0;
      stalls_on = $urandom_range(0, 3) != 0;
      repeat ($urandom_range(3, 6)) send_window(pick_kind());
      idle_input();
      wait_drained();
    end while (samples_sent < ITEM_TARGET - STEADY_ITEMS);
  endtask

  // Last stretch: no idling on either side, back-to-back windows.
  task automatic test_steady_stream();
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    apply_config(20972, 0, 2);
    repeat (3) send_window(WIN_CYCLES);
    send_window(WIN_NOISE);
    idle_input();
    wait_drained();
  endtask

  initial begin
    rst                 <= 1'b1;
    cfg_bus.valid       <= 1'b0;
    cfg_bus.index       <= REG_GAIN;
    cfg_bus.data        <= '0;
    smp_bus.valid       <= 1'b0;
    smp_bus.sample      <= '0;
    smp_bus.last_sample <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_directed_crossings();
    test_config_extremes();
    test_window_limit();
    test_backpressure();
    test_random_windows();
    test_steady_stream();

    $display("Covered %0d sample beats in %0d windows across %0d register writes.",
             samples_sent, windows_sent, cfg_writes);
    $display("Checked %0d results (%0d successful windows), %0d mismatches.",
             results_checked, windows_ok, errors);
    if (errors == 0 && pending_rms.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
